[rtl/scadc_pkg.sv]
// Shared types and constants for the skin conductance block.
// No dependencies; imported by every module under rtl.
package scadc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 26;
  localparam int COND_W    = 16;
  localparam int SCALE_W   = 10;
  localparam int DIV_STEPS = VALUE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  localparam logic [SAMPLE_W-1:0] CUTOFF_RESET = 16'hF3C0;
  localparam logic [VALUE_W-1:0]  SPIKE_RESET  = 26'd21000;
  localparam logic [SCALE_W-1:0]  SCALE        = 10'd1000;
  localparam logic [SAMPLE_W:0]   FULL_SCALE   = 17'h10000;
  localparam logic [COND_W-1:0]   COND_MAX     = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_CUTOFF  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT = 1'b1;

  typedef struct packed {
    logic load;      // capture the sample and classify it
    logic mul;       // form 1000 * numerator and clear the remainder
    logic div_step;  // one restoring division step
    logic diff;      // register the distance from the last value
    logic finish;    // write the result beat and update the state
  } dp_cmd_t;

  typedef struct packed {
    logic special;   // open contact or zero sample, no division needed
    logic out_free;  // output register can take a new beat
  } dp_status_t;

endpackage

[rtl/scadc_ctrl.sv]
// Controller state machine: sequences load, multiply, division steps,
// spike test and result write. Depends on scadc_pkg.
module scadc_ctrl import scadc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (status.special) begin
          state_next = S_FIN;
        end else begin
          count_next = CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count - 1'b1;
        if (count == '0) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

[rtl/scadc_dp.sv]
// Datapath: configuration registers, scale multiply, restoring divider,
// spike filter state and the output register. Depends on scadc_pkg.
module scadc_dp import scadc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  input  logic [SAMPLE_W-1:0]  adc_sample,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [COND_W-1:0]    conductance,
  output logic                 spike_rejected,
  output logic                 out_of_range
);

  logic [SAMPLE_W-1:0] adc_cutoff;
  logic [VALUE_W-1:0]  spike_limit;
  logic [VALUE_W-1:0]  last_accepted;

  logic [SAMPLE_W-1:0] sample;
  logic                is_oor;
  logic                is_zero;
  logic [VALUE_W-1:0]  quot;
  logic [SAMPLE_W-1:0] rem;
  logic [VALUE_W-1:0]  gap;

  logic [SAMPLE_W:0]   twice;
  logic [SAMPLE_W-1:0] numer;
  logic [SAMPLE_W:0]   rem_shift;
  logic [SAMPLE_W:0]   rem_sub;
  logic                fits;
  logic                spike;
  logic [VALUE_W-1:0]  shown;
  logic [COND_W-1:0]   shown_sat;

  // A doubled sample at or past full scale gives a zero numerator.
  assign twice = {sample, 1'b0};
  assign numer = twice[SAMPLE_W] ? '0 : SAMPLE_W'(FULL_SCALE - twice);

  assign rem_shift = {rem, quot[VALUE_W-1]};
  assign rem_sub   = rem_shift - {1'b0, sample};
  assign fits      = (rem_shift >= {1'b0, sample});

  assign spike     = (gap > spike_limit);
  assign shown     = spike ? last_accepted : quot;
  assign shown_sat = (|shown[VALUE_W-1:COND_W]) ? COND_MAX : shown[COND_W-1:0];

  assign status.special  = is_oor | is_zero;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_cutoff  <= CUTOFF_RESET;
      spike_limit <= SPIKE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADC_CUTOFF:  adc_cutoff  <= cfg_data[SAMPLE_W-1:0];
        REG_SPIKE_LIMIT: spike_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample  <= adc_sample;
      is_oor  <= (adc_sample >= adc_cutoff);
      is_zero <= (adc_sample == '0);
    end
    if (cmd.mul) begin
      quot <= VALUE_W'(numer) * VALUE_W'(SCALE);
      rem  <= '0;
    end
    if (cmd.div_step) begin
      quot <= {quot[VALUE_W-2:0], fits};
      rem  <= fits ? rem_sub[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
    end
    if (cmd.diff) begin
      gap <= (quot >= last_accepted) ? (quot - last_accepted) : (last_accepted - quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (!is_oor && !is_zero && !spike) begin
          last_accepted <= quot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_oor) begin
        conductance    <= '0;
        spike_rejected <= 1'b0;
        out_of_range   <= 1'b1;
      end else if (is_zero) begin
        conductance    <= COND_MAX;
        spike_rejected <= 1'b0;
        out_of_range   <= 1'b0;
      end else begin
        conductance    <= shown_sat;
        spike_rejected <= spike;
        out_of_range   <= 1'b0;
      end
    end
  end

endmodule

[rtl/skin_conductance_from_adc_top.sv]
// Channel   Signals                                       Direction
// in        in_valid, in_ready, adc_sample                 into block
// out       out_valid, out_ready, conductance,             out of block
//           spike_rejected, out_of_range
// cfg       cfg_we, cfg_index, cfg_data                    into block
//
// A regular sample passes from accept to result through load, multiply,
// 26 steps of the one-bit-per-cycle restoring divider, spike distance, write.
// Open contact and zero samples skip the divider and the spike distance step.
// Reset restores the register defaults and clears the last accepted value.
// A result waiting in the output register stalls only the final write step.
// Top level of the skin conductance block. Depends on scadc_pkg,
// scadc_ctrl and scadc_dp.
module skin_conductance_from_adc_top import scadc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  adc_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COND_W-1:0]    conductance,
  output logic                 spike_rejected,
  output logic                 out_of_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  scadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scadc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adc_sample     (adc_sample),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .conductance    (conductance),
    .spike_rejected (spike_rejected),
    .out_of_range   (out_of_range)
  );

endmodule
